FILE: hw/rtl/ehbl_pkg.sv
package ehbl_pkg;

	localparam int DIR_BITS = 65536;
	localparam int BIT_AW   = $clog2(DIR_BITS);
	localparam int MASK_W   = $clog2(DIR_BITS + 1);
	localparam int ROW_SW   = 5;
	localparam int ROW_W    = 1 << ROW_SW;
	localparam int ROW_AW   = BIT_AW - ROW_SW;
	localparam int ROWS     = (DIR_BITS + ROW_W - 1) / ROW_W;
	localparam int HASH_W   = 32;
	localparam int OUT_W    = 16;
	localparam int IDX_W    = 6;

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_LOCATE = 2'd1,
		CMD_MARK   = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_READ_ONLY = 2'd1,
		ST_BEYOND    = 2'd2
	} status_code_t;

	// controller to datapath
	typedef struct packed {
		logic         hash_en;
		logic         walk_init;
		logic         walk_rd;
		logic         walk_step;
		logic         walk_done;
		logic         mark_rd;
		logic         mark_wr;
		logic         clr_en;
		logic         out_load;
		logic         out_is_mark;
		status_code_t out_status;
	} ehbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic read_only;
		logic last_valid;
		logic last_beyond;
		logic bit_beyond;
		logic bit_set;
		logic clr_last;
		logic out_free;
	} ehbl_sts_t;

	function automatic logic [IDX_W-1:0] nib_val(input logic [3:0] n);
		logic [IDX_W-1:0] v;
		case (n)
			4'd0:    v = 6'd61;
			4'd1:    v = 6'd57;
			4'd2:    v = 6'd53;
			4'd3:    v = 6'd49;
			4'd4:    v = 6'd45;
			4'd5:    v = 6'd41;
			4'd6:    v = 6'd37;
			4'd7:    v = 6'd33;
			4'd8:    v = 6'd29;
			4'd9:    v = 6'd25;
			4'd10:   v = 6'd21;
			4'd11:   v = 6'd17;
			4'd12:   v = 6'd13;
			4'd13:   v = 6'd9;
			4'd14:   v = 6'd5;
			default: v = 6'd1;
		endcase
		return v;
	endfunction

	function automatic logic [HASH_W-1:0] word_val(input logic [IDX_W-1:0] i);
		logic [HASH_W-1:0] w;
		case (i)
			6'd0:    w = 32'o6100151277;
			6'd1:    w = 32'o6106161736;
			6'd2:    w = 32'o6452611562;
			6'd3:    w = 32'o5001724107;
			6'd4:    w = 32'o2614772546;
			6'd5:    w = 32'o4120731531;
			6'd6:    w = 32'o4665262210;
			6'd7:    w = 32'o7347467531;
			6'd8:    w = 32'o6735253126;
			6'd9:    w = 32'o6042345173;
			6'd10:   w = 32'o3072226605;
			6'd11:   w = 32'o1464164730;
			6'd12:   w = 32'o3247435524;
			6'd13:   w = 32'o7652510057;
			6'd14:   w = 32'o1546775256;
			6'd15:   w = 32'o5714532133;
			6'd16:   w = 32'o6173260402;
			6'd17:   w = 32'o7517101630;
			6'd18:   w = 32'o2431460343;
			6'd19:   w = 32'o1743245566;
			6'd20:   w = 32'o0261675137;
			6'd21:   w = 32'o2433103631;
			6'd22:   w = 32'o3421772437;
			6'd23:   w = 32'o4447707466;
			6'd24:   w = 32'o4435620103;
			6'd25:   w = 32'o3757017115;
			6'd26:   w = 32'o3641531772;
			6'd27:   w = 32'o6767633246;
			6'd28:   w = 32'o2673230344;
			6'd29:   w = 32'o0260612216;
			6'd30:   w = 32'o4133454451;
			6'd31:   w = 32'o0615531516;
			6'd32:   w = 32'o6137717526;
			6'd33:   w = 32'o2574116560;
			6'd34:   w = 32'o2304023373;
			6'd35:   w = 32'o7061702261;
			6'd36:   w = 32'o5153031405;
			6'd37:   w = 32'o5322056705;
			6'd38:   w = 32'o7401116734;
			6'd39:   w = 32'o6552375715;
			6'd40:   w = 32'o6165233473;
			6'd41:   w = 32'o5311063631;
			6'd42:   w = 32'o1212221723;
			6'd43:   w = 32'o1052267235;
			6'd44:   w = 32'o6000615237;
			6'd45:   w = 32'o1075222665;
			6'd46:   w = 32'o6330216006;
			6'd47:   w = 32'o4402355630;
			6'd48:   w = 32'o1451177262;
			6'd49:   w = 32'o2000133436;
			6'd50:   w = 32'o6025467062;
			6'd51:   w = 32'o7121076461;
			6'd52:   w = 32'o3123433522;
			6'd53:   w = 32'o1010635225;
			6'd54:   w = 32'o1716177066;
			6'd55:   w = 32'o5161746527;
			6'd56:   w = 32'o1736635071;
			6'd57:   w = 32'o6243505026;
			6'd58:   w = 32'o3637211610;
			6'd59:   w = 32'o1756474365;
			6'd60:   w = 32'o4723077174;
			6'd61:   w = 32'o3642763134;
			6'd62:   w = 32'o5750130273;
			default: w = 32'o3655541561;
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/ehbl_ctrl.sv
module ehbl_ctrl import ehbl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	output logic       in_stall,
	input  ehbl_sts_t  sts,
	output ehbl_cmd_t  dp_cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_ADDR,
		S_WALK_TEST,
		S_MARK_RD,
		S_MARK_WR,
		S_OUT
	} state_t;

	state_t       state_q;
	status_code_t res_status_q;
	logic         res_mark_q;
	logic         accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		dp_cmd             = '0;
		dp_cmd.out_is_mark = res_mark_q;
		dp_cmd.out_status  = res_status_q;
		unique case (state_q)
			S_CLEAR: begin
				dp_cmd.clr_en = 1'b1;
			end
			S_IDLE: begin
				if (accept && cmd == CMD_KEY) begin
					dp_cmd.hash_en = 1'b1;
				end
				if (accept && cmd == CMD_LOCATE) begin
					dp_cmd.walk_init = 1'b1;
				end
			end
			S_WALK_ADDR: begin
				// a probe past the directory reads as clear, no memory access
				if (sts.bit_beyond) begin
					dp_cmd.walk_done = 1'b1;
				end else begin
					dp_cmd.walk_rd = 1'b1;
				end
			end
			S_WALK_TEST: begin
				if (sts.bit_set) begin
					dp_cmd.walk_step = 1'b1;
				end else begin
					dp_cmd.walk_done = 1'b1;
				end
			end
			S_MARK_RD: begin
				dp_cmd.mark_rd = 1'b1;
			end
			S_MARK_WR: begin
				dp_cmd.mark_wr = 1'b1;
			end
			S_OUT: begin
				dp_cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			res_status_q <= ST_OK;
			res_mark_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_LOCATE: begin
								res_mark_q   <= 1'b0;
								res_status_q <= ST_OK;
								state_q      <= S_WALK_ADDR;
							end
							CMD_MARK: begin
								res_mark_q <= 1'b1;
								if (sts.read_only) begin
									res_status_q <= ST_READ_ONLY;
									state_q      <= S_OUT;
								end else if (!sts.last_valid) begin
									res_status_q <= ST_OK;
									state_q      <= S_OUT;
								end else if (sts.last_beyond) begin
									res_status_q <= ST_BEYOND;
									state_q      <= S_OUT;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_MARK_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_WALK_ADDR: begin
					state_q <= sts.bit_beyond ? S_OUT : S_WALK_TEST;
				end
				S_WALK_TEST: begin
					state_q <= sts.bit_set ? S_WALK_ADDR : S_OUT;
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/ehbl_dp.sv
module ehbl_dp import ehbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	input  logic [7:0]        key_byte,
	input  ehbl_cmd_t         dp_cmd,
	output ehbl_sts_t         sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HASH_W-1:0] hash_value,
	output logic [OUT_W-1:0]  bucket_number,
	output logic [OUT_W-1:0]  split_mask,
	output logic [1:0]        status
);

	logic [ROW_W-1:0]  bitmap [ROWS];

	logic              read_only_q;
	logic [IDX_W-1:0]  nib_idx_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] walk_hash_q;
	logic [MASK_W-1:0] mask_q;
	logic [BIT_AW-1:0] last_idx_q;
	logic              last_beyond_q;
	logic              last_valid_q;
	logic [ROW_AW-1:0] clr_addr_q;
	logic [ROW_W-1:0]  rd_data_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]        idx_lo;
	logic [IDX_W-1:0]        idx_hi;
	logic [MASK_W-1:0]       blk;
	logic [MASK_W:0]         bitno;
	logic                    bit_beyond;
	logic [OUT_W+MASK_W-1:0] blk_ext;
	logic [OUT_W+MASK_W-1:0] mask_ext;
	logic [ROW_AW-1:0]       rd_addr;
	logic [ROW_AW-1:0]       wr_addr;
	logic [ROW_W-1:0]        wr_data;
	logic                    wr_en;

	// low nibble first, both table words summed in one go
	assign idx_lo = nib_idx_q + nib_val(key_byte[3:0]);
	assign idx_hi = idx_lo + nib_val(key_byte[7:4]);

	assign blk        = walk_hash_q[MASK_W-1:0] & mask_q;
	assign bitno      = {1'b0, blk} + {1'b0, mask_q};
	assign bit_beyond = bitno >= (MASK_W + 1)'(DIR_BITS);
	assign blk_ext    = {{OUT_W{1'b0}}, blk};
	assign mask_ext   = {{OUT_W{1'b0}}, mask_q};

	assign rd_addr = dp_cmd.mark_rd ? last_idx_q[BIT_AW-1:ROW_SW] : bitno[BIT_AW-1:ROW_SW];
	assign wr_en   = dp_cmd.clr_en || dp_cmd.mark_wr;
	assign wr_addr = dp_cmd.clr_en ? clr_addr_q : last_idx_q[BIT_AW-1:ROW_SW];
	assign wr_data = dp_cmd.clr_en ? '0
		: (rd_data_q | (ROW_W'(1) << last_idx_q[ROW_SW-1:0]));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bitmap[wr_addr] <= wr_data;
		end
		if (dp_cmd.walk_rd || dp_cmd.mark_rd) begin
			rd_data_q <= bitmap[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_only_q   <= 1'b0;
			nib_idx_q     <= '0;
			hash_q        <= '0;
			last_idx_q    <= '0;
			last_beyond_q <= 1'b0;
			last_valid_q  <= 1'b0;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				read_only_q <= cfg_data;
			end
			if (dp_cmd.hash_en) begin
				nib_idx_q <= idx_hi;
				hash_q    <= hash_q + word_val(idx_lo) + word_val(idx_hi);
			end else if (dp_cmd.walk_init) begin
				nib_idx_q <= '0;
				hash_q    <= '0;
			end
			if (dp_cmd.walk_done) begin
				last_idx_q    <= bitno[BIT_AW-1:0];
				last_beyond_q <= bit_beyond;
				last_valid_q  <= 1'b1;
			end
			if (dp_cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + ROW_AW'(1);
			end
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.walk_init) begin
			walk_hash_q <= hash_q;
			mask_q      <= '0;
		end else if (dp_cmd.walk_step) begin
			mask_q <= {mask_q[MASK_W-2:0], 1'b1};
		end
		if (dp_cmd.out_load) begin
			if (dp_cmd.out_is_mark) begin
				hash_value    <= '0;
				bucket_number <= '0;
				split_mask    <= '0;
			end else begin
				hash_value    <= walk_hash_q;
				bucket_number <= blk_ext[OUT_W-1:0];
				split_mask    <= mask_ext[OUT_W-1:0];
			end
			status <= dp_cmd.out_status;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.read_only   = read_only_q;
	assign sts.last_valid  = last_valid_q;
	assign sts.last_beyond = last_beyond_q;
	assign sts.bit_beyond  = bit_beyond;
	assign sts.bit_set     = rd_data_q[bitno[ROW_SW-1:0]];
	assign sts.clr_last    = (clr_addr_q == ROW_AW'(ROWS - 1));
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

FILE: hw/rtl/extendible_hash_bucket_locate.sv
// Extendible-hash bucket locator. A key is fed one byte per request (cmd key byte) and
// each byte is absorbed in one hash update, both nibbles at once. An end-of-key request
// walks the split bitmap with masks 0, 1, 3, 7 ... and returns hash, bucket and mask;
// each bitmap probe goes through a registered read, as the bitmap sits in a memory of
// 32-bit rows with a registered read port, while a probe past the end of the bitmap
// reads as clear with no memory access. A mark-split request does a read-modify-write
// of one row, or skips it when it is refused or has nothing to mark. After reset the
// bitmap is cleared one row a cycle (2048 rows for 65536 bits) and no request is taken
// until that pass ends. A result sits in an output register, so a pending result that
// is stalled only blocks the next locate or mark from finishing, not key bytes. The
// configuration port is always ready and should only be written while the block is idle.
module extendible_hash_bucket_locate import ehbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [7:0]        key_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HASH_W-1:0] hash_value,
	output logic [OUT_W-1:0]  bucket_number,
	output logic [OUT_W-1:0]  split_mask,
	output logic [1:0]        status
);

	ehbl_cmd_t dp_cmd;
	ehbl_sts_t sts;

	assign cfg_ready = 1'b1;

	ehbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.sts      (sts),
		.dp_cmd   (dp_cmd)
	);

	ehbl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.key_byte      (key_byte),
		.dp_cmd        (dp_cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hash_value    (hash_value),
		.bucket_number (bucket_number),
		.split_mask    (split_mask),
		.status        (status)
	);

endmodule
